// ===== sv/smx_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and control types of the splitmix generator
package smx_pkg;

  localparam int unsigned DataW   = 64;
  localparam int unsigned HalfW   = 32;
  localparam int unsigned OpW     = 2;
  localparam int unsigned BoundW  = 32;
  localparam int unsigned ProbW   = 54;
  localparam int unsigned FracW   = 53;
  localparam int unsigned DivCntW = 6;

  localparam int unsigned ShiftPre  = 30;
  localparam int unsigned ShiftMid  = 27;
  localparam int unsigned ShiftPost = 31;
  localparam int unsigned UnitShift = DataW - FracW;

  localparam logic [DataW-1:0] GoldenStep = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [DataW-1:0] MixMulA    = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [DataW-1:0] MixMulB    = 64'h94d0_49bb_1331_11eb;

  typedef enum logic [OpW-1:0] {
    OP_RAW     = 2'd0,
    OP_BOUNDED = 2'd1,
    OP_UNIT    = 2'd2,
    OP_CHANCE  = 2'd3
  } smx_op_e;

  typedef enum logic [1:0] {
    MUL_LL = 2'd0,
    MUL_LH = 2'd1,
    MUL_HL = 2'd2
  } smx_mul_e;

  typedef struct packed {
    logic     latch;
    logic     advance;
    logic     mul_en;
    smx_mul_e mul_sel;
    logic     acc_load;
    logic     acc_add;
    logic     use_mul_b;
    logic     xor_shift;
    logic     div_init;
    logic     div_step;
    logic     res_load;
  } smx_cmd_t;

  typedef struct packed {
    smx_op_e op;
    logic    in_zero_bound;
  } smx_status_t;

endpackage

// ===== sv/smx_if.sv =====
`timescale 1ns / 1ps
// request and result channel interfaces of the splitmix generator
interface smx_req_if;
  import smx_pkg::*;
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    op;
  logic [BoundW-1:0] bound;
  logic [ProbW-1:0]  probability;

  modport source (output valid, output op, output bound, output probability, input ready);
  modport sink   (input valid, input op, input bound, input probability, output ready);
endinterface

interface smx_rsp_if;
  import smx_pkg::*;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] value;
  logic             hit;

  modport source (output valid, output value, output hit, input ready);
  modport sink   (input valid, input value, input hit, output ready);
endinterface

// ===== sv/splitmix_random_generator_core.sv =====
`timescale 1ns / 1ps
// splitmix64 generator with raw, bounded, unit-fraction and chance requests
//
// channels: req_i carries op, bound and probability; rsp_o carries value and hit,
// both valid/ready, one transfer on each edge where valid and ready are high.
// cfg_we_i with cfg_seed_i loads the counter with seed plus the golden step;
// write it only while no request is in flight.
// one request is worked at a time. after a request transfer the controller
// advances the counter, runs the two mix rounds and loads the result into the
// output register; bounded with a nonzero bound first runs the one-bit-per-cycle
// remainder unit over the mixed value, and a zero bound skips to the result load.
// the two 64-bit multiplies share one 32x32 multiplier, three partial
// products each.
// req_i.ready is high while the controller is idle, also while an earlier
// result waits in the output register; if the receiver stalls, the next
// result waits until that register is taken.
// reset puts the counter at the golden step (seed zero) and empties the output.
module splitmix_random_generator_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  smx_req_if.sink                   req_i,
  smx_rsp_if.source                 rsp_o,
  input  logic                      cfg_we_i,
  input  logic [smx_pkg::DataW-1:0] cfg_seed_i
);
  import smx_pkg::*;

  smx_cmd_t    cmd;
  smx_status_t status;

  smx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  smx_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_seed_i (cfg_seed_i),
    .in_op_i    (req_i.op),
    .in_bound_i (req_i.bound),
    .in_prob_i  (req_i.probability),
    .cmd_i      (cmd),
    .status_o   (status),
    .value_o    (rsp_o.value),
    .hit_o      (rsp_o.hit)
  );

endmodule

// ===== sv/smx_dp.sv =====
`timescale 1ns / 1ps
// datapath: counter, shared 32x32 multiplier, bit-serial modulo and result register
module smx_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [smx_pkg::DataW-1:0]  cfg_seed_i,
  input  logic [smx_pkg::OpW-1:0]    in_op_i,
  input  logic [smx_pkg::BoundW-1:0] in_bound_i,
  input  logic [smx_pkg::ProbW-1:0]  in_prob_i,
  input  smx_pkg::smx_cmd_t          cmd_i,
  output smx_pkg::smx_status_t       status_o,
  output logic [smx_pkg::DataW-1:0]  value_o,
  output logic                       hit_o
);
  import smx_pkg::*;

  logic [DataW-1:0]  counter_q, counter_d;
  logic [DataW-1:0]  ctr_next;
  logic [DataW-1:0]  z_q, z_d;
  logic [DataW-1:0]  acc_q, acc_d;
  logic [DataW-1:0]  prod_q, prod_d;
  logic [HalfW-1:0]  mul_a, mul_b;
  logic [DataW-1:0]  mul_k;
  logic [DataW-1:0]  acc_mixed;
  logic [BoundW-1:0] rem_q, rem_d;
  logic [BoundW:0]   rem_sh;
  smx_op_e           op_q;
  logic [BoundW-1:0] bound_q;
  logic [ProbW-1:0]  prob_q;
  logic [FracW-1:0]  frac;
  logic [DataW-1:0]  value_q, value_d;
  logic              hit_q, hit_d;

  assign ctr_next = counter_q + GoldenStep;
  assign mul_k    = cmd_i.use_mul_b ? MixMulB : MixMulA;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_LL: begin
        mul_a = z_q[HalfW-1:0];
        mul_b = mul_k[HalfW-1:0];
      end
      MUL_LH: begin
        mul_a = z_q[HalfW-1:0];
        mul_b = mul_k[DataW-1:HalfW];
      end
      MUL_HL: begin
        mul_a = z_q[DataW-1:HalfW];
        mul_b = mul_k[HalfW-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d    = DataW'(mul_a) * DataW'(mul_b);
  assign acc_mixed = cmd_i.use_mul_b ? (acc_q ^ (acc_q >> ShiftPost))
                                     : (acc_q ^ (acc_q >> ShiftMid));

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_load) begin
      acc_d = prod_q;
    end else if (cmd_i.acc_add) begin
      acc_d = acc_q + {prod_q[HalfW-1:0], {HalfW{1'b0}}};
    end
  end

  assign rem_sh = {rem_q, z_q[DataW-1]};

  always_comb begin
    rem_d = rem_q;
    if (cmd_i.latch || cmd_i.div_init) begin
      rem_d = '0;
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, bound_q}) begin
        rem_d = BoundW'(rem_sh - {1'b0, bound_q});
      end else begin
        rem_d = rem_sh[BoundW-1:0];
      end
    end
  end

  always_comb begin
    z_d = z_q;
    if (cmd_i.advance) begin
      z_d = ctr_next ^ (ctr_next >> ShiftPre);
    end else if (cmd_i.xor_shift) begin
      z_d = acc_mixed;
    end else if (cmd_i.div_step) begin
      z_d = {z_q[DataW-2:0], 1'b0};
    end
  end

  always_comb begin
    counter_d = counter_q;
    if (cfg_we_i) begin
      counter_d = cfg_seed_i + GoldenStep;
    end else if (cmd_i.advance) begin
      counter_d = ctr_next;
    end
  end

  assign frac = z_q[DataW-1:UnitShift];

  always_comb begin
    hit_d = 1'b0;
    case (op_q)
      OP_RAW:     value_d = z_q;
      OP_BOUNDED: value_d = DataW'(rem_q);
      OP_UNIT:    value_d = DataW'(frac);
      OP_CHANCE: begin
        value_d = DataW'(frac);
        hit_d   = ({1'b0, frac} < prob_q);
      end
      default:    value_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= GoldenStep;
    end else begin
      counter_q <= counter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q    <= z_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.latch) begin
      op_q    <= smx_op_e'(in_op_i);
      bound_q <= in_bound_i;
      prob_q  <= in_prob_i;
    end
    if (cmd_i.res_load) begin
      value_q <= value_d;
      hit_q   <= hit_d;
    end
  end

  assign status_o.op            = op_q;
  assign status_o.in_zero_bound = (smx_op_e'(in_op_i) == OP_BOUNDED) && (in_bound_i == '0);
  assign value_o                = value_q;
  assign hit_o                  = hit_q;

endmodule

// ===== sv/smx_ctrl.sv =====
`timescale 1ns / 1ps
// controller: sequences the mix rounds, the modulo and the result handoff
module smx_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  smx_pkg::smx_status_t status_i,
  output smx_pkg::smx_cmd_t    cmd_o
);
  import smx_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_ADV  = 10'b00_0000_0010,
    S_M0   = 10'b00_0000_0100,
    S_M1   = 10'b00_0000_1000,
    S_M2   = 10'b00_0001_0000,
    S_M3   = 10'b00_0010_0000,
    S_XS   = 10'b00_0100_0000,
    S_FIN  = 10'b00_1000_0000,
    S_DIV  = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } smx_state_e;

  smx_state_e         state_q, state_d;
  logic               rnd_q, rnd_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    rnd_d   = rnd_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = status_i.in_zero_bound ? S_DONE : S_ADV;
        end
      end
      S_ADV: begin
        cmd_o.advance = 1'b1;
        rnd_d         = 1'b0;
        state_d       = S_M0;
      end
      S_M0: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_LL;
        cmd_o.use_mul_b = rnd_q;
        state_d         = S_M1;
      end
      S_M1: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_LH;
        cmd_o.use_mul_b = rnd_q;
        cmd_o.acc_load  = 1'b1;
        state_d         = S_M2;
      end
      S_M2: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_HL;
        cmd_o.use_mul_b = rnd_q;
        cmd_o.acc_add   = 1'b1;
        state_d         = S_M3;
      end
      S_M3: begin
        cmd_o.acc_add = 1'b1;
        state_d       = S_XS;
      end
      S_XS: begin
        cmd_o.xor_shift = 1'b1;
        cmd_o.use_mul_b = rnd_q;
        if (rnd_q) begin
          state_d = S_FIN;
        end else begin
          rnd_d   = 1'b1;
          state_d = S_M0;
        end
      end
      S_FIN: begin
        if (status_i.op == OP_BOUNDED) begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rnd_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/smx_checker.sv =====
`timescale 1ns / 1ps
// port-level assertions of the splitmix generator and their bind
module smx_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [smx_pkg::DataW-1:0] out_value_i,
  input logic                      out_hit_i
);
  import smx_pkg::*;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("request taken while another is in flight");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && !out_valid_i) |=> !out_valid_i)
    else $error("result appeared one cycle after request transfer");

  a_hit_is_fraction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_hit_i) |-> (out_value_i[DataW-1:FracW] == '0))
    else $error("hit set on a value that is not a unit fraction");

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped while stalled");

  a_value_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(out_value_i) && $stable(out_hit_i)))
    else $error("result changed while stalled");

endmodule

bind splitmix_random_generator_core smx_checker u_smx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_value_i (rsp_o.value),
  .out_hit_i   (rsp_o.hit)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the splitmix generator core: directed and random requests
module tb;
  import smx_pkg::*;

  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 80;
  localparam int unsigned RandPerSeed  = 250;
  localparam logic [ProbW-1:0] UnitOne = 54'h20_0000_0000_0000;

  typedef struct {
    smx_op_e           op;
    logic [BoundW-1:0] bound;
    logic [ProbW-1:0]  prob;
  } draw_req_t;

  typedef struct {
    logic [DataW-1:0] value;
    logic             hit;
  } draw_res_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [DataW-1:0] cfg_seed_i;

  smx_req_if req_if ();
  smx_rsp_if rsp_if ();

  splitmix_random_generator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_seed_i (cfg_seed_i)
  );

  draw_req_t        req_backlog[$];
  draw_res_t        result_due[$];
  logic [DataW-1:0] model_counter;
  draw_req_t        drv_next;
  draw_res_t        want;
  bit               calm;
  int               send_gap = 0;
  int               stall_left = 0;
  int               hold_left = 0;
  int               holds_wanted = 0;
  int               holds_run = 0;
  int               mismatches = 0;
  int               checked = 0;
  int               accepted_cnt = 0;
  int               op_cnt[4] = '{0, 0, 0, 0};
  int               zero_bounds = 0;
  int               hits = 0;
  int               seeds_used = 0;
  int               cycle_count = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [DataW-1:0] splitmix_finalize(logic [DataW-1:0] c);
    logic [DataW-1:0] z;
    z = (c ^ (c >> ShiftPre)) * MixMulA;
    z = (z ^ (z >> ShiftMid)) * MixMulB;
    return z ^ (z >> ShiftPost);
  endfunction

  function automatic draw_res_t predict_draw(smx_op_e op, logic [BoundW-1:0] bound,
                                             logic [ProbW-1:0] prob);
    draw_res_t        r;
    logic [DataW-1:0] mixed;
    logic [ProbW-1:0] limit;
    r.value = '0;
    r.hit   = 1'b0;
    mixed   = '0;
    limit   = (prob > UnitOne) ? UnitOne : prob;
    // a zero bound leaves the counter alone
    if (!(op == OP_BOUNDED && bound == '0)) begin
      model_counter = model_counter + GoldenStep;
      mixed = splitmix_finalize(model_counter);
    end
    case (op)
      OP_RAW: begin
        r.value = mixed;
      end
      OP_BOUNDED: begin
        if (bound != '0) r.value = mixed % {32'b0, bound};
      end
      OP_UNIT: begin
        r.value = mixed >> UnitShift;
      end
      default: begin
        r.value = mixed >> UnitShift;
        r.hit   = (r.value < {10'b0, limit});
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  function automatic void queue_req(smx_op_e op, logic [BoundW-1:0] bound,
                                    logic [ProbW-1:0] prob);
    draw_req_t q;
    q.op    = op;
    q.bound = bound;
    q.prob  = prob;
    req_backlog = {req_backlog, q};
  endfunction

  function automatic void queue_random_req();
    logic [BoundW-1:0] b;
    logic [ProbW-1:0]  p;
    logic [DataW-1:0]  wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       b = '0;
      1:       b = $urandom_range(1, 16);
      2:       b = 32'd1 << $urandom_range(0, 31);
      3:       b = 32'hffff_ffff - $urandom_range(0, 3);
      default: b = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0:       p = '0;
      1:       p = UnitOne;
      2:       p = UnitOne | {1'b0, wide[52:0]};
      3:       p = UnitOne - 1 - $urandom_range(0, 15);
      4:       p = wide[53:0];
      default: p = {1'b0, wide[52:0]};
    endcase
    queue_req(smx_op_e'($urandom_range(0, 3)), b, p);
  endfunction

  task automatic flag_mismatch(string what, logic [DataW-1:0] want_v, logic want_h,
                               logic [DataW-1:0] got_v, logic got_h);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch, %s: expected value %h hit %b, got value %h hit %b",
               what, want_v, want_h, got_v, got_h);
  endtask

  task automatic wait_idle();
    while (req_backlog.size() != 0 || req_if.valid || result_due.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_seed(logic [DataW-1:0] s);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_seed_i <= s;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    model_counter = s + GoldenStep;
    seeds_used++;
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        result_due = {result_due, predict_draw(smx_op_e'(req_if.op), req_if.bound,
                                               req_if.probability)};
        accepted_cnt++;
        op_cnt[req_if.op]++;
        if (req_if.op == OP_BOUNDED && req_if.bound == '0) zero_bounds++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          drv_next = req_backlog.pop_front();
          req_if.op          <= drv_next.op;
          req_if.bound       <= drv_next.bound;
          req_if.probability <= drv_next.prob;
          req_if.valid       <= 1'b1;
          send_gap = calm ? 0 : pick_gap();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_run < holds_wanted) begin
      hold_left <= HoldCycles;
      holds_run <= holds_run + 1;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rsp_if.valid && rsp_if.ready) begin
      checked++;
      if (result_due.size() == 0) begin
        flag_mismatch("result with nothing expected", '0, 1'b0, rsp_if.value, rsp_if.hit);
      end else begin
        want = result_due.pop_front();
        if (rsp_if.value !== want.value || rsp_if.hit !== want.hit)
          flag_mismatch("wrong result", want.value, want.hit, rsp_if.value, rsp_if.hit);
        if (rsp_if.hit === 1'b1) hits++;
      end
    end
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= (hold_left == 0);
      if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL splitmix_random_generator_core");
    $finish;
  end

  initial begin
    logic [DataW-1:0] seeds[6];
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_seed_i         = '0;
    req_if.valid       = 1'b0;
    req_if.op          = OP_RAW;
    req_if.bound       = '0;
    req_if.probability = '0;
    rsp_if.ready       = 1'b0;
    model_counter      = GoldenStep;
    calm               = 1'b0;
    seeds = '{64'd0, 64'hffff_ffff_ffff_ffff, 64'd1, 64'h8000_0000_0000_0000,
              {$urandom, $urandom}, {$urandom, $urandom}};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed pass on the reset counter
    @(negedge clk_i);
    queue_req(OP_RAW, '0, '0);
    queue_req(OP_UNIT, 32'hffff_ffff, 54'h3f_ffff_ffff_ffff);
    queue_req(OP_CHANCE, '0, '0);
    queue_req(OP_CHANCE, '0, UnitOne);
    queue_req(OP_CHANCE, '0, 54'h3f_ffff_ffff_ffff);
    queue_req(OP_CHANCE, '0, UnitOne - 1);
    queue_req(OP_CHANCE, '0, 54'd1);
    queue_req(OP_CHANCE, '0, 54'h10_0000_0000_0000);
    queue_req(OP_BOUNDED, '0, '0);
    queue_req(OP_RAW, '0, '0);
    queue_req(OP_BOUNDED, 32'd1, '0);
    queue_req(OP_BOUNDED, 32'hffff_ffff, '0);
    queue_req(OP_BOUNDED, 32'd2, '0);
    queue_req(OP_BOUNDED, 32'h8000_0000, '0);
    queue_req(OP_BOUNDED, '0, '0);
    queue_req(OP_BOUNDED, '0, UnitOne);
    queue_req(OP_UNIT, '0, '0);
    queue_req(OP_RAW, 32'hffff_ffff, 54'h3f_ffff_ffff_ffff);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      write_seed(seeds[p]);
      @(negedge clk_i);
      calm = (p == 1);
      for (int i = 0; i < RandPerSeed; i++) queue_random_req();
      if (p == 2 || p == 4) holds_wanted++;
      wait_idle();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (result_due.size() != 0) begin
      mismatches += result_due.size();
      $display("%0d expected results never arrived", result_due.size());
    end
    $display("ran %0d requests over %0d seeds: raw %0d, bounded %0d, unit %0d, chance %0d",
             accepted_cnt, seeds_used + 1, op_cnt[OP_RAW], op_cnt[OP_BOUNDED],
             op_cnt[OP_UNIT], op_cnt[OP_CHANCE]);
    $display("%0d results checked, %0d zero bounds, %0d chance hits, %0d long hold-offs",
             checked, zero_bounds, hits, holds_run);
    if (mismatches == 0) begin
      $display("PASS splitmix_random_generator_core");
    end else begin
      $display("FAIL splitmix_random_generator_core");
    end
    $finish;
  end

endmodule
